[src/msi_pkg.sv]
package msi_pkg;

    // field widths
    localparam int LON_W  = 20;
    localparam int LAT_W  = 19;
    localparam int MODE_W = 3;
    localparam int ZROW_W = 5;
    localparam int ZCOL_W = 6;
    localparam int SROW_W = 7;
    localparam int SCOL_W = 7;
    localparam int ONUM_W = 8;
    localparam int TAIL_W = 7;
    localparam int SUB_W  = 3;

    // 1:1M cell size and finest (1:10k) sheet size, arc-seconds
    localparam int LAT_ZONE_SEC = 14400;
    localparam int LON_ZONE_SEC = 21600;
    localparam int ROW_STEP_SEC = 150;
    localparam int COL_STEP_SEC = 225;
    localparam int ZONE_COL_BASE = 31;

    // reciprocal multipliers, rounded down so the estimate is q or q-1
    localparam int LAT_Q_SH  = 20;
    localparam int LAT_Q_MUL = (1 << LAT_Q_SH) / LAT_ZONE_SEC;
    localparam int LON_Q_SH  = 21;
    localparam int LON_Q_MUL = (1 << LON_Q_SH) / LON_ZONE_SEC;
    localparam int ROW_Q_SH  = 14;
    localparam int ROW_Q_MUL = (1 << ROW_Q_SH) / ROW_STEP_SEC;
    localparam int COL_Q_SH  = 15;
    localparam int COL_Q_MUL = (1 << COL_Q_SH) / COL_STEP_SEC;

    localparam int MUL_W   = 8;               // constant multiplier width
    localparam int LAT_P_W = LAT_W + MUL_W;   // 27
    localparam int LON_P_W = LON_W + MUL_W;   // 28
    localparam int ZQ_W    = 6;               // zone quotient
    localparam int DB_W    = 14;              // offset in 1:1M cell, latitude
    localparam int DL_W    = 15;              // offset in 1:1M cell, longitude
    localparam int DB_P_W  = DB_W + MUL_W;
    localparam int DL_P_W  = DL_W + MUL_W;
    localparam int IDX_W   = 7;               // 1:10k row/col index 0..95
    localparam int REM_W   = 15;

    typedef enum logic [MODE_W-1:0] {
        SCALE_1M   = 3'd0,
        SCALE_500K = 3'd1,
        SCALE_250K = 3'd2,
        SCALE_100K = 3'd3,
        SCALE_50K  = 3'd4,
        SCALE_25K  = 3'd5,
        SCALE_10K  = 3'd6,
        SCALE_BAD  = 3'd7
    } t_scale;

    // indices handed to the final sheet-number stage
    typedef struct packed {
        t_scale             mode;
        logic [ZQ_W-1:0]    zq;
        logic [ZQ_W-1:0]    lq;
        logic [IDX_W-1:0]   r96;
        logic [IDX_W-1:0]   c96;
    } t_msi_idx;

    typedef struct packed {
        logic [ZROW_W-1:0]  zone_row;
        logic [ZCOL_W-1:0]  zone_col;
        logic [SROW_W-1:0]  sheet_row;
        logic [SCOL_W-1:0]  sheet_col;
        logic [ONUM_W-1:0]  old_number;
        logic [TAIL_W-1:0]  old_tail;
        logic [SUB_W-1:0]   old_subquadrant;
        logic               scale_error;
    } t_msi_rsp;

endpackage

[src/msi_req_if.sv]
interface msi_req_if;
    logic                         valid;
    logic                         ready;
    logic [msi_pkg::LON_W-1:0]    longitude_sec;
    logic [msi_pkg::LAT_W-1:0]    latitude_sec;
    logic [msi_pkg::MODE_W-1:0]   mode;

    modport source (output valid, output longitude_sec, output latitude_sec, output mode,
                    input ready);
    modport sink   (input valid, input longitude_sec, input latitude_sec, input mode,
                    output ready);
endinterface

[src/msi_rsp_if.sv]
interface msi_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [msi_pkg::ZROW_W-1:0]   zone_row;
    logic [msi_pkg::ZCOL_W-1:0]   zone_col;
    logic [msi_pkg::SROW_W-1:0]   sheet_row;
    logic [msi_pkg::SCOL_W-1:0]   sheet_col;
    logic [msi_pkg::ONUM_W-1:0]   old_number;
    logic [msi_pkg::TAIL_W-1:0]   old_tail;
    logic [msi_pkg::SUB_W-1:0]    old_subquadrant;
    logic                         scale_error;

    modport source (output valid, output zone_row, output zone_col, output sheet_row,
                    output sheet_col, output old_number, output old_tail,
                    output old_subquadrant, output scale_error, input ready);
    modport sink   (input valid, input zone_row, input zone_col, input sheet_row,
                    input sheet_col, input old_number, input old_tail,
                    input old_subquadrant, input scale_error, output ready);
endinterface

[src/msi_sheet_calc.sv]
// Sheet row/col and old-style number fields from the 1:10k grid indices.
module msi_sheet_calc (
    input  msi_pkg::t_msi_idx i_idx,
    output msi_pkg::t_msi_rsp o_rsp
);
    logic [3:0]                   r8, c8;
    logic [7:0]                   r_prod, c_prod;
    logic [1:0]                   r_third, c_third;
    logic [msi_pkg::IDX_W-1:0]    rq, cq, n_rows;
    logic [3:0]                   nr, nc, ng, nrev;
    logic [msi_pkg::ONUM_W-1:0]   num;

    always_comb begin
        r8      = i_idx.r96[6:3];
        c8      = i_idx.c96[6:3];
        // x/3 for x < 12
        r_prod  = 8'(r8) * 8'd11;
        c_prod  = 8'(c8) * 8'd11;
        r_third = r_prod[6:5];
        c_third = c_prod[6:5];

        rq     = '0;
        cq     = '0;
        n_rows = 7'd1;
        case (i_idx.mode)
            msi_pkg::SCALE_500K: begin
                rq = 7'(r_third[1]); cq = 7'(c_third[1]); n_rows = 7'd2;
            end
            msi_pkg::SCALE_250K: begin
                rq = 7'(r_third); cq = 7'(c_third); n_rows = 7'd4;
            end
            msi_pkg::SCALE_100K: begin
                rq = 7'(r8); cq = 7'(c8); n_rows = 7'd12;
            end
            msi_pkg::SCALE_50K: begin
                rq = i_idx.r96 >> 2; cq = i_idx.c96 >> 2; n_rows = 7'd24;
            end
            msi_pkg::SCALE_25K: begin
                rq = i_idx.r96 >> 1; cq = i_idx.c96 >> 1; n_rows = 7'd48;
            end
            msi_pkg::SCALE_10K: begin
                rq = i_idx.r96; cq = i_idx.c96; n_rows = 7'd96;
            end
            default: begin
                rq = '0; cq = '0; n_rows = 7'd1;
            end
        endcase

        // old number: at 500k..100k the sheet itself, below that its 1:100k parent
        if (i_idx.mode == msi_pkg::SCALE_500K || i_idx.mode == msi_pkg::SCALE_250K
                || i_idx.mode == msi_pkg::SCALE_100K) begin
            nr = rq[3:0];
            nc = cq[3:0];
            ng = n_rows[3:0];
        end else begin
            nr = r8;
            nc = c8;
            ng = 4'd12;
        end
        nrev = ng - 4'd1 - nr;
        num  = 8'(nrev) * 8'(ng) + 8'(nc) + 8'd1;

        o_rsp = '0;
        if (i_idx.mode == msi_pkg::SCALE_BAD) begin
            o_rsp.scale_error = 1'b1;
        end else begin
            o_rsp.zone_row  = 5'(i_idx.zq + 6'd1);
            o_rsp.zone_col  = i_idx.lq + 6'(msi_pkg::ZONE_COL_BASE);
            o_rsp.sheet_row = n_rows - rq;
            o_rsp.sheet_col = cq + 7'd1;
            if (i_idx.mode != msi_pkg::SCALE_1M) begin
                o_rsp.old_number = num;
            end
            case (i_idx.mode)
                msi_pkg::SCALE_10K: begin
                    o_rsp.old_tail = 7'({~i_idx.r96[2:0], i_idx.c96[2:0]}) + 7'd1;
                end
                msi_pkg::SCALE_50K: begin
                    o_rsp.old_tail = 7'({~i_idx.r96[2], i_idx.c96[2]}) + 7'd1;
                end
                msi_pkg::SCALE_25K: begin
                    o_rsp.old_tail        = 7'({~i_idx.r96[2], i_idx.c96[2]}) + 7'd1;
                    o_rsp.old_subquadrant = 3'({~i_idx.r96[1], i_idx.c96[1]}) + 3'd1;
                end
                default: begin
                    o_rsp.old_tail = '0;
                end
            endcase
        end
    end

endmodule

[src/map_sheet_index_from_position.sv]
// Map sheet indexer for the national topographic grid. A request carries an
// east longitude and north latitude in whole arc-seconds and a scale select;
// the response gives the 1:1M zone row/column, the new-style sheet row/column
// at that scale, and the old-style number, tail and sub-quadrant. Points on a
// sheet edge go to the cell to their north/east. Scale select 7 returns
// scale_error with all other fields zero. Five register stages carry a
// request from stage 1 to the stage 5 output register that drives o_rsp,
// and one request enters per cycle while the response side keeps up. Each
// stage holds its own valid bit and advances whenever the stage after it is
// empty or moving, so empty slots fill up during a response stall and
// i_req.ready drops only once every stage holds a request.
module map_sheet_index_from_position (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msi_req_if.sink           i_req,
    msi_rsp_if.source         o_rsp
);
    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    // stage 1: reciprocal estimate of the 1:1M zone quotients
    logic [msi_pkg::LAT_W-1:0]   r1_lat;
    logic [msi_pkg::LON_W-1:0]   r1_lon;
    msi_pkg::t_scale             r1_mode;
    logic [msi_pkg::ZQ_W-1:0]    r1_zq, r1_lq;
    logic [msi_pkg::LAT_P_W-1:0] lat_prod;
    logic [msi_pkg::LON_P_W-1:0] lon_prod;

    // stage 2: corrected zone quotient, offsets inside the 1:1M cell
    msi_pkg::t_scale             r2_mode;
    logic [msi_pkg::ZQ_W-1:0]    r2_zq, r2_lq, n2_zq, n2_lq;
    logic [msi_pkg::DB_W-1:0]    r2_db, n2_db;
    logic [msi_pkg::DL_W-1:0]    r2_dl, n2_dl;
    logic [20:0]                 lat_rem, lon_rem;

    // stage 3: reciprocal estimate of the 1:10k grid index
    msi_pkg::t_scale             r3_mode;
    logic [msi_pkg::ZQ_W-1:0]    r3_zq, r3_lq;
    logic [msi_pkg::DB_W-1:0]    r3_db;
    logic [msi_pkg::DL_W-1:0]    r3_dl;
    logic [msi_pkg::IDX_W-1:0]   r3_r96, r3_c96;
    logic [msi_pkg::DB_P_W-1:0]  db_prod;
    logic [msi_pkg::DL_P_W-1:0]  dl_prod;

    // stage 4: corrected grid index
    msi_pkg::t_msi_idx           r4_idx, n4_idx;
    logic [msi_pkg::REM_W-1:0]   row_rem, col_rem;

    // stage 5: output register
    msi_pkg::t_msi_rsp           r5_rsp, n5_rsp;

    // each stage moves when its successor is empty or moving
    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || o_rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stg_en[i] = !r_vld[i] || stg_en[i+1];
        end
    end

    assign i_req.ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (stg_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 1
    always_comb begin
        lat_prod = msi_pkg::LAT_P_W'(i_req.latitude_sec)
                 * msi_pkg::LAT_P_W'(msi_pkg::LAT_Q_MUL);
        lon_prod = msi_pkg::LON_P_W'(i_req.longitude_sec)
                 * msi_pkg::LON_P_W'(msi_pkg::LON_Q_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r1_lat  <= i_req.latitude_sec;
            r1_lon  <= i_req.longitude_sec;
            r1_mode <= msi_pkg::t_scale'(i_req.mode);
            r1_zq   <= msi_pkg::ZQ_W'(lat_prod >> msi_pkg::LAT_Q_SH);
            r1_lq   <= msi_pkg::ZQ_W'(lon_prod >> msi_pkg::LON_Q_SH);
        end
    end

    // stage 2: the estimate is low by at most one, so one compare fixes it
    always_comb begin
        lat_rem = 21'(r1_lat) - 21'(r1_zq) * 21'(msi_pkg::LAT_ZONE_SEC);
        lon_rem = 21'(r1_lon) - 21'(r1_lq) * 21'(msi_pkg::LON_ZONE_SEC);
        if (lat_rem >= 21'(msi_pkg::LAT_ZONE_SEC)) begin
            n2_zq = r1_zq + 6'd1;
            n2_db = msi_pkg::DB_W'(lat_rem - 21'(msi_pkg::LAT_ZONE_SEC));
        end else begin
            n2_zq = r1_zq;
            n2_db = msi_pkg::DB_W'(lat_rem);
        end
        if (lon_rem >= 21'(msi_pkg::LON_ZONE_SEC)) begin
            n2_lq = r1_lq + 6'd1;
            n2_dl = msi_pkg::DL_W'(lon_rem - 21'(msi_pkg::LON_ZONE_SEC));
        end else begin
            n2_lq = r1_lq;
            n2_dl = msi_pkg::DL_W'(lon_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r2_mode <= r1_mode;
            r2_zq   <= n2_zq;
            r2_lq   <= n2_lq;
            r2_db   <= n2_db;
            r2_dl   <= n2_dl;
        end
    end

    // stage 3: every sheet size divides the 1:10k sheet grid (96 x 96 per cell)
    always_comb begin
        db_prod = msi_pkg::DB_P_W'(r2_db) * msi_pkg::DB_P_W'(msi_pkg::ROW_Q_MUL);
        dl_prod = msi_pkg::DL_P_W'(r2_dl) * msi_pkg::DL_P_W'(msi_pkg::COL_Q_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r3_mode <= r2_mode;
            r3_zq   <= r2_zq;
            r3_lq   <= r2_lq;
            r3_db   <= r2_db;
            r3_dl   <= r2_dl;
            r3_r96  <= msi_pkg::IDX_W'(db_prod >> msi_pkg::ROW_Q_SH);
            r3_c96  <= msi_pkg::IDX_W'(dl_prod >> msi_pkg::COL_Q_SH);
        end
    end

    // stage 4
    always_comb begin
        row_rem = msi_pkg::REM_W'(r3_db)
                - msi_pkg::REM_W'(r3_r96) * msi_pkg::REM_W'(msi_pkg::ROW_STEP_SEC);
        col_rem = msi_pkg::REM_W'(r3_dl)
                - msi_pkg::REM_W'(r3_c96) * msi_pkg::REM_W'(msi_pkg::COL_STEP_SEC);
        n4_idx.mode = r3_mode;
        n4_idx.zq   = r3_zq;
        n4_idx.lq   = r3_lq;
        n4_idx.r96  = (row_rem >= msi_pkg::REM_W'(msi_pkg::ROW_STEP_SEC))
                    ? r3_r96 + 7'd1 : r3_r96;
        n4_idx.c96  = (col_rem >= msi_pkg::REM_W'(msi_pkg::COL_STEP_SEC))
                    ? r3_c96 + 7'd1 : r3_c96;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r4_idx <= n4_idx;
        end
    end

    // stage 5: scale-dependent rows, columns and old-style numbering
    msi_sheet_calc u_calc (
        .i_idx (r4_idx),
        .o_rsp (n5_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r5_rsp <= n5_rsp;
        end
    end

    assign o_rsp.valid           = r_vld[NSTG-1];
    assign o_rsp.zone_row        = r5_rsp.zone_row;
    assign o_rsp.zone_col        = r5_rsp.zone_col;
    assign o_rsp.sheet_row       = r5_rsp.sheet_row;
    assign o_rsp.sheet_col       = r5_rsp.sheet_col;
    assign o_rsp.old_number      = r5_rsp.old_number;
    assign o_rsp.old_tail        = r5_rsp.old_tail;
    assign o_rsp.old_subquadrant = r5_rsp.old_subquadrant;
    assign o_rsp.scale_error     = r5_rsp.scale_error;

endmodule
